// ===== rtl/srli_pkg.sv =====
// Shared types, codes and defaults for the sorted row-list intersection block.
`default_nettype none

package srli_pkg;

  // Default values for the top-level parameters.
  localparam int unsigned LIST_DEPTH_DEF = 1024;
  localparam int unsigned ROW_BITS_DEF   = 20;

  // Fixed widths of the transaction fields.
  localparam int unsigned OP_FIELD_W    = 3;
  localparam int unsigned ROW_FIELD_W   = 20;
  localparam int unsigned COUNT_FIELD_W = 2;
  localparam int unsigned POS_FIELD_W   = 10;
  localparam int unsigned TOTAL_FIELD_W = 11;

  // Operation codes carried in the operation field.
  localparam logic [OP_FIELD_W-1:0] OP_APPEND_A = 3'd0;
  localparam logic [OP_FIELD_W-1:0] OP_APPEND_B = 3'd1;
  localparam logic [OP_FIELD_W-1:0] OP_APPEND_C = 3'd2;
  localparam logic [OP_FIELD_W-1:0] OP_RUN      = 3'd3;
  localparam logic [OP_FIELD_W-1:0] OP_READ     = 3'd4;

  // List counts that select the merge mode.
  localparam logic [COUNT_FIELD_W-1:0] LISTS_TWO   = 2'd2;
  localparam logic [COUNT_FIELD_W-1:0] LISTS_THREE = 2'd3;

  typedef struct packed {
    logic [OP_FIELD_W-1:0]    operation;
    logic [ROW_FIELD_W-1:0]   row_value;
    logic [COUNT_FIELD_W-1:0] list_count;
    logic [POS_FIELD_W-1:0]   read_position;
  } item_t;

  typedef struct packed {
    logic [TOTAL_FIELD_W-1:0] match_total;
    logic [ROW_FIELD_W-1:0]   row_out;
    logic                     row_valid;
    logic                     overflow_seen;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_MERGE = 3'b010,
    ST_EMIT  = 3'b100
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic append_a;
    logic append_b;
    logic append_c;
    logic run_start;
    logic read_start;
    logic merge_step;
    logic merge_end;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic merge_done;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/srli_dp.sv =====
// Datapath: list and result memories, lengths, merge indices and output register.
`default_nettype none

module srli_dp #(
  parameter int unsigned LIST_DEPTH = srli_pkg::LIST_DEPTH_DEF,
  parameter int unsigned ROW_BITS   = srli_pkg::ROW_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire srli_pkg::item_t  item_i,
  input  wire srli_pkg::cmd_t   cmd_i,
  output srli_pkg::status_t     status_o,
  output srli_pkg::result_t     result_o
);

  localparam int unsigned AW       = $clog2(LIST_DEPTH);
  localparam int unsigned CW       = $clog2(LIST_DEPTH + 1);
  localparam int unsigned RW       = ROW_BITS;
  localparam int unsigned ROW_FW   = srli_pkg::ROW_FIELD_W;
  localparam int unsigned TOTAL_FW = srli_pkg::TOTAL_FIELD_W;

  logic [RW-1:0] mem_a   [LIST_DEPTH];
  logic [RW-1:0] mem_b   [LIST_DEPTH];
  logic [RW-1:0] mem_c   [LIST_DEPTH];
  logic [RW-1:0] mem_res [LIST_DEPTH];

  logic [RW-1:0] rd_a_q, rd_b_q, rd_c_q, rd_res_q;

  logic [CW-1:0] len_a_q, len_b_q, len_c_q;
  logic [CW-1:0] len_a_d, len_b_d, len_c_d;
  logic [CW-1:0] idx_a_q, idx_b_q, idx_c_q;
  logic [CW-1:0] idx_a_d, idx_b_d, idx_c_d;
  logic [CW-1:0] res_len_q, res_len_d;
  logic [srli_pkg::COUNT_FIELD_W-1:0] lists_q, lists_d;
  logic          ovf_q, ovf_d;
  logic          rd_ok_q, rd_ok_d;
  srli_pkg::result_t result_q;

  logic [RW-1:0] row_in;
  logic          full_a, full_b, full_c;
  logic          wr_a, wr_b, wr_c, wr_res;
  logic          mode_two, mode_three;
  logic          end_a, end_b, end_c, done;
  logic          eq_ab, eq_ac, lt_ab;
  logic [RW-1:0] top;
  logic          emit, adv_a, adv_b, adv_c;

  assign row_in = RW'(item_i.row_value);
  assign full_a = len_a_q == CW'(LIST_DEPTH);
  assign full_b = len_b_q == CW'(LIST_DEPTH);
  assign full_c = len_c_q == CW'(LIST_DEPTH);
  assign wr_a   = cmd_i.append_a && !full_a;
  assign wr_b   = cmd_i.append_b && !full_b;
  assign wr_c   = cmd_i.append_c && !full_c;

  // Merge step decision on the heads read out for the current indices.
  always_comb begin
    mode_three = lists_q == srli_pkg::LISTS_THREE;
    mode_two   = lists_q == srli_pkg::LISTS_TWO;
    end_a      = idx_a_q >= len_a_q;
    end_b      = idx_b_q >= len_b_q;
    end_c      = idx_c_q >= len_c_q;
    done       = end_a || ((mode_two || mode_three) && end_b) || (mode_three && end_c);
    eq_ab      = rd_a_q == rd_b_q;
    eq_ac      = rd_a_q == rd_c_q;
    lt_ab      = rd_a_q < rd_b_q;
    top        = rd_a_q;
    if (rd_b_q > top) begin
      top = rd_b_q;
    end
    if (rd_c_q > top) begin
      top = rd_c_q;
    end
    if (mode_three) begin
      emit  = eq_ab && eq_ac;
      adv_a = emit || (rd_a_q < top);
      adv_b = emit || (rd_b_q < top);
      adv_c = emit || (rd_c_q < top);
    end else if (mode_two) begin
      emit  = eq_ab;
      adv_a = eq_ab || lt_ab;
      adv_b = !lt_ab;
      adv_c = 1'b0;
    end else begin
      emit  = 1'b1;
      adv_a = 1'b1;
      adv_b = 1'b0;
      adv_c = 1'b0;
    end
  end

  assign status_o.merge_done = done;
  assign wr_res = cmd_i.merge_step && emit && (res_len_q < CW'(LIST_DEPTH));

  always_comb begin
    len_a_d   = len_a_q;
    len_b_d   = len_b_q;
    len_c_d   = len_c_q;
    idx_a_d   = idx_a_q;
    idx_b_d   = idx_b_q;
    idx_c_d   = idx_c_q;
    res_len_d = res_len_q;
    lists_d   = lists_q;
    ovf_d     = ovf_q;
    rd_ok_d   = rd_ok_q;
    if (wr_a) begin
      len_a_d = len_a_q + CW'(1);
    end
    if (wr_b) begin
      len_b_d = len_b_q + CW'(1);
    end
    if (wr_c) begin
      len_c_d = len_c_q + CW'(1);
    end
    if ((cmd_i.append_a && full_a) || (cmd_i.append_b && full_b) ||
        (cmd_i.append_c && full_c)) begin
      ovf_d = 1'b1;
    end
    if (cmd_i.run_start) begin
      idx_a_d   = '0;
      idx_b_d   = '0;
      idx_c_d   = '0;
      res_len_d = '0;
      lists_d   = item_i.list_count;
      rd_ok_d   = 1'b0;
    end
    if (cmd_i.read_start) begin
      rd_ok_d = 32'(item_i.read_position) < 32'(res_len_q);
    end
    if (cmd_i.merge_step) begin
      idx_a_d = idx_a_q + CW'(adv_a);
      idx_b_d = idx_b_q + CW'(adv_b);
      idx_c_d = idx_c_q + CW'(adv_c);
    end
    if (wr_res) begin
      res_len_d = res_len_q + CW'(1);
    end
    if (cmd_i.merge_end) begin
      len_a_d = '0;
      len_b_d = '0;
      len_c_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_a_q   <= '0;
      len_b_q   <= '0;
      len_c_q   <= '0;
      idx_a_q   <= '0;
      idx_b_q   <= '0;
      idx_c_q   <= '0;
      res_len_q <= '0;
      lists_q   <= '0;
      ovf_q     <= 1'b0;
      rd_ok_q   <= 1'b0;
    end else begin
      len_a_q   <= len_a_d;
      len_b_q   <= len_b_d;
      len_c_q   <= len_c_d;
      idx_a_q   <= idx_a_d;
      idx_b_q   <= idx_b_d;
      idx_c_q   <= idx_c_d;
      res_len_q <= res_len_d;
      lists_q   <= lists_d;
      ovf_q     <= ovf_d;
      rd_ok_q   <= rd_ok_d;
    end
  end

  // The list memories are read every cycle at the next index, so the head
  // registers always hold the entries at the current indices.
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[len_a_q[AW-1:0]] <= row_in;
    end
    rd_a_q <= mem_a[idx_a_d[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      mem_b[len_b_q[AW-1:0]] <= row_in;
    end
    rd_b_q <= mem_b[idx_b_d[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wr_c) begin
      mem_c[len_c_q[AW-1:0]] <= row_in;
    end
    rd_c_q <= mem_c[idx_c_d[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wr_res) begin
      mem_res[res_len_q[AW-1:0]] <= rd_a_q;
    end
    if (cmd_i.read_start) begin
      rd_res_q <= mem_res[AW'(item_i.read_position)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      result_q.match_total   <= TOTAL_FW'(res_len_q);
      result_q.row_out       <= rd_ok_q ? ROW_FW'(rd_res_q) : '0;
      result_q.row_valid     <= rd_ok_q;
      result_q.overflow_seen <= ovf_q;
    end
  end

  assign result_o = result_q;

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.merge_step |-> (idx_a_q < len_a_q))
    else $error("merge step taken with list A exhausted");

  a_result_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_len_q <= CW'(LIST_DEPTH))
    else $error("result length exceeds the store depth");

  a_overflow_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag cleared without reset");

endmodule

`default_nettype wire

// ===== rtl/srli_ctrl.sv =====
// Controller: state machine that sequences appends, reads, merge runs and output loads.
`default_nettype none

module srli_ctrl (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  input  wire logic [srli_pkg::OP_FIELD_W-1:0]    in_op_i,
  output logic                                    in_stall_o,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  input  wire srli_pkg::status_t                  status_i,
  output srli_pkg::cmd_t                          cmd_o
);

  srli_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      srli_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (in_op_i)
            srli_pkg::OP_APPEND_A: cmd_o.append_a = 1'b1;
            srli_pkg::OP_APPEND_B: cmd_o.append_b = 1'b1;
            srli_pkg::OP_APPEND_C: cmd_o.append_c = 1'b1;
            srli_pkg::OP_RUN: begin
              cmd_o.run_start = 1'b1;
              state_d         = srli_pkg::ST_MERGE;
            end
            srli_pkg::OP_READ: begin
              cmd_o.read_start = 1'b1;
              state_d          = srli_pkg::ST_EMIT;
            end
            default: ;
          endcase
        end
      end
      srli_pkg::ST_MERGE: begin
        if (status_i.merge_done) begin
          cmd_o.merge_end = 1'b1;
          state_d         = srli_pkg::ST_EMIT;
        end else begin
          cmd_o.merge_step = 1'b1;
        end
      end
      srli_pkg::ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = srli_pkg::ST_IDLE;
        end
      end
      default: state_d = srli_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srli_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != srli_pkg::ST_IDLE;
  assign out_valid_o = out_valid_q;

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == srli_pkg::ST_EMIT))
    else $error("output became valid without an emit");

  a_emit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srli_pkg::ST_EMIT && out_valid_q && out_stall_i)
      |=> (state_q == srli_pkg::ST_EMIT))
    else $error("emit left while the output slot was still occupied");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state is not one-hot");

endmodule

`default_nettype wire

// ===== rtl/sorted_row_list_intersection.sv =====
// Top level of the sorted row-list intersection block.
`default_nettype none

// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   in_item_i  (srli_pkg::item_t)
// out      output     out_valid_o / out_stall_i out_item_o (srli_pkg::result_t)
//
// Appends are accepted back to back.
// A read transaction reads the result store on acceptance and then loads the
// output register from the emit state once the output slot is free.
// A run transaction makes S merge steps after acceptance, where S is at most
// the summed lengths of the lists in use; it then closes the merge and loads
// the output register. The merge advances one step per cycle through the
// registered read ports of the list memories.
// Reset clears the list lengths, the result length and the overflow flag; the
// memories need no clearing pass. A stalled output holds its transaction while
// appends continue to be accepted; a further run or read waits for the slot.

module sorted_row_list_intersection #(
  parameter int unsigned LIST_DEPTH = srli_pkg::LIST_DEPTH_DEF,
  parameter int unsigned ROW_BITS   = srli_pkg::ROW_BITS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire srli_pkg::item_t in_item_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output srli_pkg::result_t    out_item_o
);

  // Commands and status pass only through these two structs.
  srli_pkg::cmd_t    cmd;
  srli_pkg::status_t status;

  // The controller decodes the operation and steps through merge and output.
  srli_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_item_i.operation),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the three list memories, the result memory, the
  // lengths, the merge indices and the output payload register.
  srli_dp #(
    .LIST_DEPTH (LIST_DEPTH),
    .ROW_BITS   (ROW_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (in_item_i),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (out_item_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the sorted row-list intersection block.
`default_nettype none

module tb;

  typedef srli_pkg::item_t   item_t;
  typedef srli_pkg::result_t result_t;

  // Field widths taken over from the package.
  localparam int unsigned OP_FIELD_W    = srli_pkg::OP_FIELD_W;
  localparam int unsigned ROW_FIELD_W   = srli_pkg::ROW_FIELD_W;
  localparam int unsigned COUNT_FIELD_W = srli_pkg::COUNT_FIELD_W;
  localparam int unsigned POS_FIELD_W   = srli_pkg::POS_FIELD_W;
  localparam int unsigned TOTAL_FIELD_W = srli_pkg::TOTAL_FIELD_W;

  // Sizes of the block as built here, and of the run.
  localparam int unsigned DEPTH         = srli_pkg::LIST_DEPTH_DEF;
  localparam int unsigned RESET_CYCLES  = 10;
  localparam int unsigned RANDOM_ITEMS  = 600;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned LIMIT_CYCLES  = 2_000_000;
  localparam int unsigned MAX_REPORTS   = 10;

  // Operation codes that the block has no use for, and the list counts that
  // the package leaves unnamed (both select the copy of list A).
  localparam logic [OP_FIELD_W-1:0]    OP_UNUSED_FIRST = 3'd5;
  localparam logic [OP_FIELD_W-1:0]    OP_UNUSED_LAST  = 3'd7;
  localparam logic [COUNT_FIELD_W-1:0] LISTS_NONE      = 2'd0;
  localparam logic [COUNT_FIELD_W-1:0] LISTS_ONE       = 2'd1;

  // Index of each list in the local copy of the list stores.
  localparam int unsigned LIST_A = 0;
  localparam int unsigned LIST_B = 1;
  localparam int unsigned LIST_C = 2;

  localparam logic [ROW_FIELD_W-1:0] ROW_MAX = '1;
  localparam logic [POS_FIELD_W-1:0] POS_MAX = '1;

  // Every input of the block holds a known value from time zero onwards.
  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    in_valid_i  = 1'b0;
  item_t   in_item_i   = '0;
  logic    out_stall_i = 1'b0;
  logic    in_stall_o;
  logic    out_valid_o;
  result_t out_item_o;

  sorted_row_list_intersection dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predicted state of the block. It is updated at the clock edge at which an
  // input transaction is accepted, so it always reflects every transaction the
  // block has taken so far, whatever the block is still busy with.
  // ---------------------------------------------------------------------------
  logic [ROW_FIELD_W-1:0] list_rows [3][DEPTH];
  int unsigned            list_len [3];
  logic [ROW_FIELD_W-1:0] common_rows [DEPTH];
  int unsigned            common_count;
  bit                     overflow_latched;

  // Results still owed by the block, oldest first.
  result_t     pending_results [$];
  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned cycle_count;

  initial begin
    list_len         = '{0, 0, 0};
    common_count     = 0;
    overflow_latched = 1'b0;
    mismatch_count   = 0;
    items_sent       = 0;
    burst_left       = 0;
    cycle_count      = 0;
  end

  // Adds a prediction at the young end of the queue.
  function automatic void owe_result(result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // A full list drops the row and raises the sticky flag; only reset clears it.
  function automatic void store_row(int unsigned idx, logic [ROW_FIELD_W-1:0] value);
    if (list_len[idx] >= DEPTH) begin
      overflow_latched = 1'b1;
    end else begin
      list_rows[idx][list_len[idx]] = value;
      list_len[idx]++;
    end
  endfunction

  function automatic void keep_common(logic [ROW_FIELD_W-1:0] value);
    if (common_count < DEPTH) begin
      common_rows[common_count] = value;
      common_count++;
    end
  endfunction

  // Merge walk over the lists in use. Lists need not be sorted: with two lists
  // the smaller head moves on, with three every head below the largest moves
  // on, and the walk ends as soon as any list in use runs out. A count of zero
  // or one copies list A. Every run empties all three lists.
  function automatic void intersect_lists(logic [COUNT_FIELD_W-1:0] lists);
    int unsigned            ia;
    int unsigned            ib;
    int unsigned            ic;
    logic [ROW_FIELD_W-1:0] ha;
    logic [ROW_FIELD_W-1:0] hb;
    logic [ROW_FIELD_W-1:0] hc;
    logic [ROW_FIELD_W-1:0] top;
    ia = 0;
    ib = 0;
    ic = 0;
    common_count = 0;
    case (lists)
      srli_pkg::LISTS_TWO: begin
        while (ia < list_len[LIST_A] && ib < list_len[LIST_B]) begin
          ha = list_rows[LIST_A][ia];
          hb = list_rows[LIST_B][ib];
          if (ha == hb) begin
            keep_common(ha);
            ia++;
            ib++;
          end else if (ha < hb) begin
            ia++;
          end else begin
            ib++;
          end
        end
      end
      srli_pkg::LISTS_THREE: begin
        while (ia < list_len[LIST_A] && ib < list_len[LIST_B] &&
               ic < list_len[LIST_C]) begin
          ha = list_rows[LIST_A][ia];
          hb = list_rows[LIST_B][ib];
          hc = list_rows[LIST_C][ic];
          if (ha == hb && ha == hc) begin
            keep_common(ha);
            ia++;
            ib++;
            ic++;
          end else begin
            top = ha;
            if (hb > top) top = hb;
            if (hc > top) top = hc;
            if (ha < top) ia++;
            if (hb < top) ib++;
            if (hc < top) ic++;
          end
        end
      end
      default: begin
        for (ia = 0; ia < list_len[LIST_A]; ia++) keep_common(list_rows[LIST_A][ia]);
      end
    endcase
    list_len = '{0, 0, 0};
  endfunction

  // Applies one accepted transaction to the predicted state and queues the
  // result it causes, if any. Unused operation codes leave everything alone.
  function automatic void predict_item(item_t it);
    result_t r;
    bit      hit;
    r = '0;
    case (it.operation)
      srli_pkg::OP_APPEND_A: store_row(LIST_A, it.row_value);
      srli_pkg::OP_APPEND_B: store_row(LIST_B, it.row_value);
      srli_pkg::OP_APPEND_C: store_row(LIST_C, it.row_value);
      srli_pkg::OP_RUN: begin
        intersect_lists(it.list_count);
        r.match_total   = TOTAL_FIELD_W'(common_count);
        r.overflow_seen = overflow_latched;
        owe_result(r);
      end
      srli_pkg::OP_READ: begin
        hit             = 32'(it.read_position) < common_count;
        r.match_total   = TOTAL_FIELD_W'(common_count);
        r.row_out       = hit ? common_rows[it.read_position] : '0;
        r.row_valid     = hit;
        r.overflow_seen = overflow_latched;
        owe_result(r);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------

  // Idle cycles before the next input transaction: mostly none or a few, now
  // and then a long one, and from time to time a burst with no gaps at all.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) burst_left = $urandom_range(20, 60);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offers one transaction and holds it steady until the block takes it. The
  // valid line is only lowered when a gap follows, so that a back-to-back
  // transaction never sees two assignments to it in one time step.
  task automatic send_item(item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_item(it);
    if (it.operation <= srli_pkg::OP_READ) items_sent++;
  endtask

  // A transaction of the given operation whose other fields are all random;
  // the block must ignore the fields that the operation does not use.
  function automatic item_t random_item(logic [OP_FIELD_W-1:0] op);
    item_t it;
    it.operation     = op;
    it.row_value     = ROW_FIELD_W'($urandom);
    it.list_count    = COUNT_FIELD_W'($urandom);
    it.read_position = POS_FIELD_W'($urandom);
    return it;
  endfunction

  task automatic send_append(logic [OP_FIELD_W-1:0] op, logic [ROW_FIELD_W-1:0] value);
    item_t it;
    it           = random_item(op);
    it.row_value = value;
    send_item(it);
  endtask

  task automatic send_run(logic [COUNT_FIELD_W-1:0] lists);
    item_t it;
    it            = random_item(srli_pkg::OP_RUN);
    it.list_count = lists;
    send_item(it);
  endtask

  task automatic send_read(logic [POS_FIELD_W-1:0] pos);
    item_t it;
    it               = random_item(srli_pkg::OP_READ);
    it.read_position = pos;
    send_item(it);
  endtask

  task automatic send_noise();
    send_item(random_item(OP_FIELD_W'($urandom_range(0, 7))));
  endtask

  // Lowers valid and waits until the block has delivered everything it owes,
  // then a few more cycles in which nothing further may come out.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: the stall line alternates between ready stretches and
  // stalls, mostly short ones, with the odd long stall or long ready spell.
  // ---------------------------------------------------------------------------
  initial begin : stall_pattern
    int unsigned ready_len;
    int unsigned hold_len;
    @(posedge rst_ni);
    forever begin
      ready_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6);
      hold_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 3);
      out_stall_i <= 1'b0;
      repeat (ready_len) @(posedge clk_i);
      if (hold_len != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_len) @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking: every accepted output transaction is compared field by
  // field with the oldest prediction. A transaction with nothing owed is a
  // failure as well.
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(string what, result_t want, result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch, %s: expected total=%0d row=%0d valid=%0b overflow=%0b",
               what, want.match_total, want.row_out, want.row_valid, want.overflow_seen);
      $display("                 got total=%0d row=%0d valid=%0b overflow=%0b",
               got.match_total, got.row_out, got.row_valid, got.overflow_seen);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pending_results.size() == 0) begin
        note_mismatch("transaction with no result owed", '0, out_item_o);
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.match_total   !== want.match_total ||
            out_item_o.row_out       !== want.row_out     ||
            out_item_o.row_valid     !== want.row_valid   ||
            out_item_o.overflow_seen !== want.overflow_seen) begin
          note_mismatch("result fields", want, out_item_o);
        end
      end
    end
  end

  // Watchdog over the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Field extremes, each operation, the zero list count, unused codes and
  // reads outside the result.
  task automatic test_directed_basics();
    int unsigned k;
    send_read('0);                  // nothing found yet after reset
    send_append(srli_pkg::OP_APPEND_A, 20'd11);
    send_run(LISTS_NONE);           // a count of zero copies list A
    send_read('0);
    send_append(srli_pkg::OP_APPEND_A, '0);
    send_append(srli_pkg::OP_APPEND_A, ROW_MAX);
    send_append(srli_pkg::OP_APPEND_B, '0);
    send_append(srli_pkg::OP_APPEND_B, ROW_MAX);
    send_append(srli_pkg::OP_APPEND_C, '0);
    send_append(srli_pkg::OP_APPEND_C, ROW_MAX);
    for (k = 32'(OP_UNUSED_FIRST); k <= 32'(OP_UNUSED_LAST); k++) begin
      send_item(random_item(OP_FIELD_W'(k)));
    end
    send_run(srli_pkg::LISTS_THREE);
    send_read(10'd0);
    send_read(10'd1);
    send_read(10'd2);               // just past the result
    send_read(POS_MAX);
    send_append(srli_pkg::OP_APPEND_A, 20'd3);
    send_append(srli_pkg::OP_APPEND_A, 20'd9);
    send_append(srli_pkg::OP_APPEND_B, 20'd9);
    send_run(srli_pkg::LISTS_TWO);
    send_read(10'd0);
    send_append(srli_pkg::OP_APPEND_A, 20'd4);
    send_run(LISTS_ONE);
    send_read(10'd0);
  endtask

  // Out-of-order and repeated rows, and walks that stop when one list runs
  // out while the others still hold rows.
  task automatic test_unsorted_lists();
    send_append(srli_pkg::OP_APPEND_A, 20'd9);
    send_append(srli_pkg::OP_APPEND_A, 20'd2);
    send_append(srli_pkg::OP_APPEND_A, 20'd5);
    send_append(srli_pkg::OP_APPEND_B, 20'd2);
    send_append(srli_pkg::OP_APPEND_B, 20'd5);
    send_append(srli_pkg::OP_APPEND_B, 20'd9);
    send_run(srli_pkg::LISTS_TWO);
    send_read(10'd0);
    send_read(10'd1);
    send_append(srli_pkg::OP_APPEND_A, 20'd8);
    send_append(srli_pkg::OP_APPEND_A, 20'd1);
    send_append(srli_pkg::OP_APPEND_A, 20'd8);
    send_append(srli_pkg::OP_APPEND_B, 20'd8);
    send_append(srli_pkg::OP_APPEND_B, 20'd3);
    send_append(srli_pkg::OP_APPEND_B, 20'd8);
    send_append(srli_pkg::OP_APPEND_B, 20'd1);
    send_append(srli_pkg::OP_APPEND_C, 20'd1);
    send_append(srli_pkg::OP_APPEND_C, 20'd8);
    send_append(srli_pkg::OP_APPEND_C, 20'd8);
    send_run(srli_pkg::LISTS_THREE);
    send_read(10'd0);
    send_read(10'd1);
    send_append(srli_pkg::OP_APPEND_A, 20'd6);
    send_append(srli_pkg::OP_APPEND_A, 20'd6);
    send_append(srli_pkg::OP_APPEND_B, 20'd6);
    send_append(srli_pkg::OP_APPEND_B, 20'd6);
    send_append(srli_pkg::OP_APPEND_B, 20'd6);
    send_run(srli_pkg::LISTS_TWO);
    send_read(10'd1);
    send_append(srli_pkg::OP_APPEND_A, 20'd1);
    send_append(srli_pkg::OP_APPEND_B, 20'd1);
    send_run(srli_pkg::LISTS_THREE);  // list C is empty, so nothing matches
  endtask

  // One well-formed sequence: ascending rows shared out among the three lists,
  // a run over a random number of lists, then reads mostly inside the result.
  // Now and then an out-of-order append or an early read slips in.
  task automatic send_list_sequence();
    int unsigned n;
    int unsigned max_step;
    int unsigned cur;
    int unsigned mask;
    int unsigned i;
    int unsigned reads;
    logic [COUNT_FIELD_W-1:0] lists;
    n        = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 100) : $urandom_range(0, 10);
    max_step = ($urandom_range(0, 1) == 0) ? 3 : 8191;
    cur      = $urandom_range(0, 32'(ROW_MAX) - n * max_step);
    for (i = 0; i < n; i++) begin
      cur += $urandom_range(1, max_step);
      mask = ($urandom_range(0, 2) == 0) ? 7 : $urandom_range(0, 7);
      if (mask[0]) send_append(srli_pkg::OP_APPEND_A, ROW_FIELD_W'(cur));
      if (mask[1]) send_append(srli_pkg::OP_APPEND_B, ROW_FIELD_W'(cur));
      if (mask[2]) send_append(srli_pkg::OP_APPEND_C, ROW_FIELD_W'(cur));
      if ($urandom_range(0, 24) == 0) begin
        send_append(OP_FIELD_W'($urandom_range(0, 2)), ROW_FIELD_W'($urandom));
      end
      if ($urandom_range(0, 29) == 0) send_read(POS_FIELD_W'($urandom));
    end
    lists = ($urandom_range(0, 7) == 0) ? LISTS_NONE : COUNT_FIELD_W'($urandom_range(1, 3));
    send_run(lists);
    reads = $urandom_range(0, 5);
    for (i = 0; i < reads; i++) begin
      if (common_count != 0 && $urandom_range(0, 4) != 0) begin
        send_read(POS_FIELD_W'($urandom_range(0, common_count - 1)));
      end else begin
        send_read(POS_FIELD_W'($urandom));
      end
    end
  endtask

  // Random part: mostly well-formed sequences, the rest short bursts of fully
  // random transactions. Once in a while the sender pauses until the block
  // has caught up completely.
  task automatic test_random_sequences();
    int unsigned start;
    int unsigned k;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        for (k = $urandom_range(1, 4); k != 0; k--) send_noise();
      end else begin
        send_list_sequence();
      end
      if ($urandom_range(0, 14) == 0) wait_for_results();
    end
  endtask

  // Fills list A past its depth. The full-size copy gives the largest match
  // total and reaches the last result position. The flag is sticky, so this
  // test comes last.
  task automatic test_list_overflow();
    int unsigned offset;
    int unsigned i;
    offset = $urandom_range(0, 999);
    for (i = 0; i < DEPTH + 2; i++) begin
      send_append(srli_pkg::OP_APPEND_A, ROW_FIELD_W'(i * 1000 + offset));
    end
    send_run(LISTS_ONE);
    send_read('0);
    send_read(POS_MAX);
    for (i = 0; i < 20; i++) send_read(POS_FIELD_W'($urandom));
    send_run(srli_pkg::LISTS_TWO);  // lists were emptied by the run
    send_read('0);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_basics();
    wait_for_results();
    test_unsorted_lists();
    wait_for_results();
    test_random_sequences();
    wait_for_results();
    test_list_overflow();
    wait_for_results();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/srli_pkg.sv
rtl/srli_dp.sv
rtl/srli_ctrl.sv
rtl/sorted_row_list_intersection.sv
tb/sv/tb.sv
